// ===== design/dpr_pkg.sv =====
package dpr_pkg;

  localparam int IN_LANES = 4;
  localparam int BYTE_W   = 8;
  localparam int PROD_W   = 2 * BYTE_W;
  localparam int USED_W   = 3;
  localparam int BIAS_W   = 32;
  localparam int MULT_W   = 31;
  localparam int SHIFT_W  = 6;
  localparam int OUT_W    = 8;

  // in_tdata layout, lowest bit first
  localparam int ACT_LSB  = 0;
  localparam int WT_LSB   = IN_LANES * BYTE_W;
  localparam int USED_LSB = 2 * IN_LANES * BYTE_W;
  localparam int BIAS_LSB = USED_LSB + USED_W;
  localparam int IN_DATA_BITS = BIAS_LSB + BIAS_W;
  localparam int IN_TDATA_W   = ((IN_DATA_BITS + 7) / 8) * 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MULT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_EN     = 2'd2;

  localparam logic [MULT_W-1:0]  RST_SCALE_MULT  = 31'd1073741824;
  localparam logic [SHIFT_W-1:0] RST_SCALE_SHIFT = 6'd30;
  localparam logic               RST_BIAS_EN     = 1'b1;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 8'sd127;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -8'sd128;
  localparam logic [OUT_W:0] POS_LIMIT = 9'd127;
  localparam logic [OUT_W:0] NEG_LIMIT = 9'd128;

  typedef struct packed {
    logic [MULT_W-1:0]  mult;
    logic [SHIFT_W-1:0] shift;
  } rq_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rq_status_t;

endpackage

// ===== design/dpr_lane.sv =====
module dpr_lane
  import dpr_pkg::*;
(
  input  logic                     clk,
  input  logic                     fire,
  input  logic                     en,
  input  logic signed [BYTE_W-1:0] act,
  input  logic signed [BYTE_W-1:0] wt,
  output logic signed [PROD_W-1:0] prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  // keep the multiply out of a mixed-sign conditional so both bytes sign-extend
  always_comb begin
    prod_nxt = '0;
    if (en) begin
      prod_nxt = act * wt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== design/dpr_accum.sv =====
module dpr_accum
  import dpr_pkg::*;
#(
  parameter int NL        = 4,
  parameter int ACC_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  logic                        s1_last,
  input  logic signed [BIAS_W-1:0]    s1_bias,
  input  logic signed [PROD_W-1:0]    prods [NL],
  input  logic                        bias_en,
  output logic                        start_r,
  output logic [ACC_WIDTH-1:0]        acc_r
);

  localparam int PSUM_W = PROD_W + $clog2(NL + 1);

  logic signed [PSUM_W-1:0]    psum;
  logic signed [ACC_WIDTH-1:0] bias_ext;
  logic [ACC_WIDTH-1:0]        sum;
  logic [ACC_WIDTH-1:0]        running_r;
  logic [ACC_WIDTH-1:0]        running_nxt;
  logic [ACC_WIDTH-1:0]        acc_nxt;

  always_comb begin
    psum = '0;
    for (int k = 0; k < NL; k++) begin
      psum = psum + PSUM_W'(prods[k]);
    end
    bias_ext = bias_en ? ACC_WIDTH'(s1_bias) : '0;
    sum      = running_r + ACC_WIDTH'(psum);
    acc_nxt  = sum + bias_ext;
    running_nxt = running_r;
    if (s1_valid) begin
      running_nxt = s1_last ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      start_r   <= 1'b0;
    end else begin
      running_r <= running_nxt;
      start_r   <= s1_valid && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_last) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== design/dpr_requant.sv =====
module dpr_requant
  import dpr_pkg::*;
#(
  parameter int ACC_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ACC_WIDTH-1:0] acc,
  input  rq_cfg_t              cfg,
  output rq_status_t           status,
  output logic [OUT_W-1:0]     out_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready
);

  localparam int LO_W = (ACC_WIDTH + 1) / 2;
  localparam int HI_W = ACC_WIDTH - LO_W;
  localparam int PW   = ACC_WIDTH + MULT_W;
  localparam int QW   = PW + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAG   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_RND   = 3'd4;
  localparam logic [2:0] ST_SHIFT = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [ACC_WIDTH-1:0]   acc_r;
  logic                   neg_r;
  logic [ACC_WIDTH-1:0]   mag_r;
  logic [LO_W+MULT_W-1:0] plo_r;
  logic [HI_W+MULT_W-1:0] phi_r;
  logic [PW-1:0]          prod_r;
  logic [QW-1:0]          rnd_r;
  logic [QW-1:0]          q_r;
  logic [QW-1:0]          half;
  logic [OUT_W-1:0]       sat;
  logic                   out_free;
  logic                   load;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r;

  assign out_free = !out_valid_r || out_tready;
  assign load     = (state_r == ST_OUT) && out_free;

  always_comb begin
    half = '0;
    if (cfg.shift != '0) begin
      half = QW'(1) << (cfg.shift - SHIFT_W'(1));
    end
  end

  // saturate the rounded magnitude back to a signed byte
  always_comb begin
    if (!neg_r) begin
      sat = (q_r > QW'(POS_LIMIT)) ? OUT_MAX : q_r[OUT_W-1:0];
    end else begin
      sat = (q_r > QW'(NEG_LIMIT)) ? OUT_MIN : OUT_W'(~q_r[OUT_W-1:0] + 1'b1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_MAG;
      ST_MAG:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_RND;
      ST_RND:   state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      acc_r <= acc;
    end
    if (state_r == ST_MAG) begin
      neg_r <= acc_r[ACC_WIDTH-1];
      mag_r <= acc_r[ACC_WIDTH-1] ? (~acc_r + ACC_WIDTH'(1)) : acc_r;
    end
    if (state_r == ST_MUL) begin
      plo_r <= mag_r[LO_W-1:0] * cfg.mult;
      phi_r <= mag_r[ACC_WIDTH-1:LO_W] * cfg.mult;
    end
    if (state_r == ST_SUM) begin
      prod_r <= PW'(plo_r) + (PW'(phi_r) << LO_W);
    end
    if (state_r == ST_RND) begin
      rnd_r <= QW'(prod_r) + half;
    end
    if (state_r == ST_SHIFT) begin
      q_r <= rnd_r >> cfg.shift;
    end
    if (load) begin
      out_data_r <= sat;
    end
  end

  assign status.busy = (state_r != ST_IDLE);
  assign status.done = load;
  assign out_tdata   = out_data_r;
  assign out_tvalid  = out_valid_r;

endmodule

// ===== design/int8_dot_product_requantizer.sv =====
// int8 dot product with requantization, one output neuron per row.
// Input channel (in_*): each transfer carries up to four activation/weight
// byte pairs; lanes below lanes_used contribute their products to a
// running sum. in_tlast marks the final transfer of a row; on it the row
// bias is added (if enabled), the sum is scaled by mult / 2^shift, rounded
// half away from zero and saturated to int8, and sent on out_*.
// Throughput: one transfer per cycle within a row. After a row's last
// transfer in_tready drops until the row result is loaded into the output
// register: lane products are registered at the transfer, then accumulated,
// then loaded into the requantizer, which runs six steps (magnitude, split
// multiply, partial sum, rounding, shift, saturate); the last step waits
// until the output register is free.
// A stalled receiver holds the result in the output register; the next row
// streams in meanwhile and only its requantizer waits for the register.
// Configuration (cfg_*) is always ready and must be written only when idle.
// Reset clears the running sum, empties the output and restores the scale
// registers to 2^30 / 2^30 with bias enabled.
module int8_dot_product_requantizer
  import dpr_pkg::*;
#(
  parameter int LANES     = 4,
  parameter int ACC_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // act_a..act_d, wt_a..wt_d, lanes_used, row_bias, zero pad
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_value
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [MULT_W-1:0]     cfg_data
);

  localparam int NL = (LANES < IN_LANES) ? LANES : IN_LANES;

  logic                     in_fire;
  logic                     busy_r, busy_nxt;
  logic                     s1_valid_r;
  logic                     s1_last_r;
  logic signed [BIAS_W-1:0] s1_bias_r;
  logic [USED_W-1:0]        lanes_used;
  logic signed [PROD_W-1:0] prods [NL];
  rq_cfg_t                  rq_cfg_r;
  logic                     bias_en_r;
  rq_status_t               rq_status;
  logic                     start;
  logic [ACC_WIDTH-1:0]     acc;

  assign in_fire    = in_tvalid && in_tready;
  assign in_tready  = !busy_r;
  assign cfg_ready  = 1'b1;
  assign lanes_used = in_tdata[USED_LSB +: USED_W];

  for (genvar k = 0; k < NL; k++) begin : g_lane
    dpr_lane u_lane (
      .clk    (clk),
      .fire   (in_fire),
      .en     (USED_W'(k) < lanes_used),
      .act    (in_tdata[ACT_LSB + k*BYTE_W +: BYTE_W]),
      .wt     (in_tdata[WT_LSB + k*BYTE_W +: BYTE_W]),
      .prod_r (prods[k])
    );
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_fire && in_tlast) begin
      busy_nxt = 1'b1;
    end else if (rq_status.done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      s1_valid_r <= 1'b0;
      rq_cfg_r.mult  <= RST_SCALE_MULT;
      rq_cfg_r.shift <= RST_SCALE_SHIFT;
      bias_en_r  <= RST_BIAS_EN;
    end else begin
      busy_r     <= busy_nxt;
      s1_valid_r <= in_fire;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCALE_MULT:  rq_cfg_r.mult  <= cfg_data;
          CFG_SCALE_SHIFT: rq_cfg_r.shift <= cfg_data[SHIFT_W-1:0];
          CFG_BIAS_EN:     bias_en_r      <= cfg_data[0];
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_last_r <= in_tlast;
      s1_bias_r <= in_tdata[BIAS_LSB +: BIAS_W];
    end
  end

  dpr_accum #(
    .NL        (NL),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1_last  (s1_last_r),
    .s1_bias  (s1_bias_r),
    .prods    (prods),
    .bias_en  (bias_en_r),
    .start_r  (start),
    .acc_r    (acc)
  );

  dpr_requant #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_requant (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .acc        (acc),
    .cfg        (rq_cfg_r),
    .status     (rq_status),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

endmodule
